/* src/hsfd_pkg.sv */
package hsfd_pkg;

    localparam int SENSOR_COUNT = 3;
    localparam int SENSOR_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    localparam int FRAME_BYTES = 7;
    localparam logic [2:0] LAST_POS = 3'(FRAME_BYTES - 1);

    localparam int K_W = 21;
    localparam logic [K_W-1:0] K_FULL = 21'd1089430;
    localparam logic [K_W-1:0] K_SHORT = 21'd544715;
    localparam int PROD_W = 12 + K_W + 1;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(32768);

    localparam logic [2:0] REG_FULL_RANGE = 3'd0;

    typedef struct packed {
        logic [1:0]         sensor_number;
        logic signed [11:0] raw_x;
        logic signed [11:0] raw_y;
        logic signed [11:0] raw_z;
        logic               sensor_failed;
        logic [2:0]         fail_mask;
        logic               scan_last;
    } t_frame_rec;

endpackage

/* src/hall_sensor_frame_decoder_core.sv */
// channel   | dir | tdata                         | tuser          | tlast
// s_axis    | in  | rx_byte                       | short_transfer | -
// m_axis    | out | sensor_number..fail_mask      | sensor_failed  | scan_last
// apb       | in  | register 0 full_range at 0x0  | -              | -
//
// one beat per cycle while the queue has room; a frame result is written into the two-entry record queue
// on its last input beat, then registered by the single multiply stage in the back end
// synchronous active-low reset clears position, parity, sensor index, fail mask, queue, output valid
// output stall fills the queue, then s_axis_tready drops; input side never waits on idle output
module hall_sensor_frame_decoder_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
    input  logic         s_axis_tuser,   // [0] short_transfer
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] sensor_number, [13:2] raw_x, [25:14] raw_y, [37:26] raw_z,
    // [54:38] scaled_x, [71:55] scaled_y, [88:72] scaled_z, [91:89] fail_mask
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tuser,   // [0] sensor_failed
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic r_full_range;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    hsfd_pkg::t_frame_rec front_rec;
    hsfd_pkg::t_frame_rec q_rec;
    hsfd_pkg::t_frame_rec out_rec;
    logic signed [16:0] sx, sy, sz;

    assign pready = 1'b1;
    assign prdata = (paddr == hsfd_pkg::REG_FULL_RANGE) ? {31'd0, r_full_range} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_range <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == hsfd_pkg::REG_FULL_RANGE) begin
            r_full_range <= pwdata[0];
        end
    end

    hsfd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_rx_byte        (s_axis_tdata),
        .i_short_transfer (s_axis_tuser),
        .o_push           (push),
        .o_rec            (front_rec),
        .i_full           (q_full)
    );

    hsfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_rec   (q_rec)
    );

    hsfd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_full_range (r_full_range),
        .i_valid      (q_valid),
        .i_rec        (q_rec),
        .o_pop        (pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_rec        (out_rec),
        .o_scaled_x   (sx),
        .o_scaled_y   (sy),
        .o_scaled_z   (sz)
    );

    assign m_axis_tdata = {4'd0, out_rec.fail_mask, sz, sy, sx,
                           out_rec.raw_z, out_rec.raw_y, out_rec.raw_x,
                           out_rec.sensor_number};
    assign m_axis_tuser = out_rec.sensor_failed;
    assign m_axis_tlast = out_rec.scan_last;

endmodule

/* src/hsfd_front.sv */
module hsfd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_short_transfer,
    output logic                o_push,
    output hsfd_pkg::t_frame_rec o_rec,
    input  logic                i_full
);

    logic [2:0] r_pos;
    logic [2:0] n_pos;
    logic [7:0] r_parity;
    logic [7:0] n_parity;
    logic [hsfd_pkg::SENSOR_W-1:0] r_sensor;
    logic [hsfd_pkg::SENSOR_W-1:0] n_sensor;
    logic [2:0] r_mask;
    logic [2:0] n_mask;
    logic [7:0] r_b0, r_b1, r_b2, r_b4, r_b5;
    logic [hsfd_pkg::SENSOR_W+1:0] sensor_ext;
    logic accept;
    logic frame_end;
    logic failed;
    logic last;
    logic [2:0] mask_now;

    assign o_ready = !i_full;
    assign accept = i_valid && o_ready;
    assign frame_end = i_short_transfer || (r_pos == hsfd_pkg::LAST_POS);
    assign failed = i_short_transfer || !((^r_parity) ^ i_rx_byte[7]);
    assign last = (r_sensor == hsfd_pkg::SENSOR_W'(hsfd_pkg::SENSOR_COUNT - 1));
    assign mask_now = failed ? (r_mask | (3'b001 << r_sensor)) : r_mask;
    assign sensor_ext = {2'b00, r_sensor};
    assign o_push = accept && frame_end;

    always_comb begin
        o_rec.sensor_number = sensor_ext[1:0];
        o_rec.raw_x = failed ? 12'sd0 : {r_b0, r_b4[7:4]};
        o_rec.raw_y = failed ? 12'sd0 : {r_b1, r_b4[3:0]};
        o_rec.raw_z = failed ? 12'sd0 : {r_b2, r_b5[3:0]};
        o_rec.sensor_failed = failed;
        o_rec.fail_mask = mask_now;
        o_rec.scan_last = last;
    end

    always_comb begin
        n_pos = r_pos;
        n_parity = r_parity;
        n_sensor = r_sensor;
        n_mask = r_mask;
        if (accept) begin
            if (frame_end) begin
                n_pos = 3'd0;
                n_parity = 8'd0;
                if (last) begin
                    n_sensor = '0;
                    n_mask = 3'd0;
                end else begin
                    n_sensor = r_sensor + 1'b1;
                    n_mask = mask_now;
                end
            end else begin
                n_pos = r_pos + 3'd1;
                n_parity = r_parity ^ i_rx_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_parity <= 8'd0;
            r_sensor <= '0;
            r_mask <= 3'd0;
        end else begin
            r_pos <= n_pos;
            r_parity <= n_parity;
            r_sensor <= n_sensor;
            r_mask <= n_mask;
        end
    end

    // frame payload bytes, byte 3 is never used
    always_ff @(posedge i_clk) begin
        if (accept && !frame_end) begin
            case (r_pos)
                3'd0: r_b0 <= i_rx_byte;
                3'd1: r_b1 <= i_rx_byte;
                3'd2: r_b2 <= i_rx_byte;
                3'd4: r_b4 <= i_rx_byte;
                3'd5: r_b5 <= i_rx_byte;
                default: ;
            endcase
        end
    end

endmodule

/* src/hsfd_queue.sv */
module hsfd_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  hsfd_pkg::t_frame_rec i_rec,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_valid,
    output hsfd_pkg::t_frame_rec o_rec
);

    hsfd_pkg::t_frame_rec r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_count;

    assign o_full = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_rec = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= 1'b0;
            r_rd <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10: r_count <= r_count + 2'd1;
                2'b01: r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* src/hsfd_back.sv */
module hsfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_full_range,
    input  logic                 i_valid,
    input  hsfd_pkg::t_frame_rec i_rec,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output hsfd_pkg::t_frame_rec o_rec,
    output logic signed [16:0]   o_scaled_x,
    output logic signed [16:0]   o_scaled_y,
    output logic signed [16:0]   o_scaled_z
);

    logic r_valid;
    hsfd_pkg::t_frame_rec r_rec;
    logic signed [16:0] r_sx, r_sy, r_sz;
    logic signed [hsfd_pkg::K_W:0] k;
    logic signed [hsfd_pkg::PROD_W-1:0] px, py, pz;

    assign k = $signed({1'b0, i_full_range ? hsfd_pkg::K_FULL : hsfd_pkg::K_SHORT});
    assign px = i_rec.raw_x * k + $signed(hsfd_pkg::ROUND_HALF);
    assign py = i_rec.raw_y * k + $signed(hsfd_pkg::ROUND_HALF);
    assign pz = i_rec.raw_z * k + $signed(hsfd_pkg::ROUND_HALF);

    assign o_pop = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_rec = r_rec;
    assign o_scaled_x = r_sx;
    assign o_scaled_y = r_sy;
    assign o_scaled_z = r_sz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // arithmetic shift by 16 gives floor of the rounded product
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
            r_sx <= px[32:16];
            r_sy <= py[32:16];
            r_sz <= pz[32:16];
        end
    end

endmodule
